// File: design/sdis_pkg.sv
// Shared types for the stable depth insertion sorter.
// Holds the command and status structs between controller and datapath.
// No dependencies.
package sdis_pkg;

  localparam int unsigned IndexBits = 8;
  localparam int unsigned DepthBits = 16;

  typedef struct packed {
    logic insert;    // take the input item into the store
    logic pop;       // move the head entry to the output register
    logic overflow;  // overflow mark for the popped item
  } sdis_cmd_t;

  typedef struct packed {
    logic full;      // store holds MAX_ENTRIES entries
    logic one_left;  // store holds exactly one entry
  } sdis_status_t;

endpackage

// File: design/sdis_datapath.sv
// Datapath of the stable depth insertion sorter: chain of compare-and-shift
// cells, entry count and output payload register.
// Depends on sdis_pkg.
module sdis_datapath #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sdis_pkg::sdis_cmd_t              cmd,
  output sdis_pkg::sdis_status_t           status,
  input  logic [sdis_pkg::IndexBits-1:0]   in_entry_index,
  input  logic signed [sdis_pkg::DepthBits-1:0] in_depth_key,
  output logic [sdis_pkg::IndexBits-1:0]   out_sorted_index,
  output logic signed [sdis_pkg::DepthBits-1:0] out_sorted_depth,
  output logic                             out_final_result,
  output logic                             out_overflow
);
  import sdis_pkg::*;

  localparam int unsigned CntBits = $clog2(MAX_ENTRIES + 1);

  logic [IndexBits-1:0]       idx_r [MAX_ENTRIES];
  logic signed [KEY_BITS-1:0] key_r [MAX_ENTRIES];
  logic [IndexBits-1:0]       idx_nxt [MAX_ENTRIES];
  logic signed [KEY_BITS-1:0] key_nxt [MAX_ENTRIES];
  logic [CntBits-1:0]         count_r, count_nxt;
  logic [MAX_ENTRIES-1:0]     gt;
  logic signed [KEY_BITS-1:0] new_key;
  logic signed [DepthBits-1:0] head_depth;

  logic [IndexBits-1:0]        sorted_index_r;
  logic signed [DepthBits-1:0] sorted_depth_r;
  logic                        final_r, overflow_r;

  // Cut or sign-extend the key to the stored width, and back for output.
  generate
    if (KEY_BITS < DepthBits) begin : g_narrow
      assign new_key    = in_depth_key[KEY_BITS-1:0];
      assign head_depth = DepthBits'(key_r[0]);
    end else begin : g_wide
      assign new_key    = KEY_BITS'(in_depth_key);
      assign head_depth = key_r[0][DepthBits-1:0];
    end
  endgenerate

  assign status.full     = (count_r == CntBits'(MAX_ENTRIES));
  assign status.one_left = (count_r == CntBits'(1));

  // Entries are sorted, so gt is a run of ones from the insert point upward.
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      gt[k] = (CntBits'(k) < count_r) && (new_key < key_r[k]);
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      idx_nxt[k] = idx_r[k];
      key_nxt[k] = key_r[k];
    end
    if (cmd.insert && !status.full) begin
      count_nxt = count_r + CntBits'(1);
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        if (gt[k]) begin
          if (k == 0 || !gt[(k == 0) ? 0 : k-1]) begin
            idx_nxt[k] = in_entry_index;
            key_nxt[k] = new_key;
          end else begin
            idx_nxt[k] = idx_r[(k == 0) ? 0 : k-1];
            key_nxt[k] = key_r[(k == 0) ? 0 : k-1];
          end
        end else if (CntBits'(k) == count_r) begin
          // take the shifted top entry when the new one lands below it
          if (k != 0 && gt[(k == 0) ? 0 : k-1]) begin
            idx_nxt[k] = idx_r[(k == 0) ? 0 : k-1];
            key_nxt[k] = key_r[(k == 0) ? 0 : k-1];
          end else begin
            idx_nxt[k] = in_entry_index;
            key_nxt[k] = new_key;
          end
        end
      end
    end else if (cmd.pop) begin
      // advance the chain toward the head
      count_nxt = count_r - CntBits'(1);
      for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
        idx_nxt[k] = idx_r[k+1];
        key_nxt[k] = key_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      idx_r[k] <= idx_nxt[k];
      key_r[k] <= key_nxt[k];
    end
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      sorted_index_r <= idx_r[0];
      sorted_depth_r <= head_depth;
      final_r        <= status.one_left;
      overflow_r     <= cmd.overflow;
    end
  end

  assign out_sorted_index = sorted_index_r;
  assign out_sorted_depth = sorted_depth_r;
  assign out_final_result = final_r;
  assign out_overflow     = overflow_r;

endmodule

// File: design/sdis_ctrl.sv
// Controller of the stable depth insertion sorter: load/emit sequencing,
// drop tracking and output valid.
// Depends on sdis_pkg.
module sdis_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_last_entry,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sdis_pkg::sdis_cmd_t    cmd,
  input  sdis_pkg::sdis_status_t status
);
  import sdis_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   dropped_r, dropped_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire, slot_free;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.insert    = 1'b0;
    cmd.pop       = 1'b0;
    cmd.overflow  = dropped_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          cmd.insert  = 1'b1;
          dropped_nxt = dropped_r || status.full;
          if (in_last_entry) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.one_left) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/stable_depth_insertion_sorter.sv
// Stable depth insertion sorter, top level.
// Instantiates sdis_ctrl and sdis_datapath; depends on sdis_pkg.
//
// Usage: send a set of entries on the in_ channel (valid/ready), each with
// an index and a signed depth key; mark the final entry with in_last_entry.
// Each accepted item is inserted by a chain of compare-and-shift cells,
// ahead of the first stored entry with a strictly greater key, so equal
// keys keep arrival order. Loading runs at one item per cycle.
// After the last item the block emits every stored entry in ascending key
// order on the out_ channel, one item per cycle while out_ready is high;
// out_final_result marks the final item and out_overflow is set on all items
// of a set in which entries beyond MAX_ENTRIES were dropped. The first result
// is popped into the output register once the emit state has a free output
// slot. in_ready is low while the N entries move into the output register;
// the emit pace is set by that single output register and the receiver.
// A stall on out_ready holds the output item and pauses the emit; the next
// set may start loading while the final item still waits.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// output. MAX_ENTRIES sets the cell count, KEY_BITS the stored key width.
module stable_depth_insertion_sorter #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sdis_pkg::IndexBits-1:0]        in_entry_index,
  input  logic signed [sdis_pkg::DepthBits-1:0] in_depth_key,
  input  logic                                  in_last_entry,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sdis_pkg::IndexBits-1:0]        out_sorted_index,
  output logic signed [sdis_pkg::DepthBits-1:0] out_sorted_depth,
  output logic                                  out_final_result,
  output logic                                  out_overflow
);
  import sdis_pkg::*;

  sdis_cmd_t    cmd;
  sdis_status_t status;

  sdis_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_last_entry (in_last_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .status        (status)
  );

  sdis_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_entry_index   (in_entry_index),
    .in_depth_key     (in_depth_key),
    .out_sorted_index (out_sorted_index),
    .out_sorted_depth (out_sorted_depth),
    .out_final_result (out_final_result),
    .out_overflow     (out_overflow)
  );

endmodule
